>>> hw/rtl/asss_pkg.sv
// ----------------------------------------------------------------------------
// asss_pkg: shared definitions for the array store with search and sort
// Sizes of the cell chain, operation and status codes, the control word that
// the sequencer broadcasts to every cell, and width conversion helpers.
// ----------------------------------------------------------------------------
package asss_pkg;

    localparam int DEPTH       = 64;
    localparam int WORD_BITS   = 32;
    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int INDEX_BITS  = 6;
    localparam int ELEM_BITS   = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Operation codes carried by func.
    localparam logic [FUNC_BITS-1:0] F_APPEND  = 3'd0;
    localparam logic [FUNC_BITS-1:0] F_LSEARCH = 3'd1;
    localparam logic [FUNC_BITS-1:0] F_SORT    = 3'd2;
    localparam logic [FUNC_BITS-1:0] F_BSEARCH = 3'd3;
    localparam logic [FUNC_BITS-1:0] F_LIST    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd3;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     pos_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Control word broadcast from the sequencer to all cells.
    typedef struct packed {
        logic  wr_en;
        pos_t  wr_idx;
        word_t wr_word;
        logic  shift;
        logic  sort_en;
        logic  phase;
        cnt_t  fill;
    } cell_ctrl_t;

    // Low WORD_BITS of the input value, zero padded if the word is wider.
    function automatic word_t value_to_word(input logic [ELEM_BITS-1:0] v);
        logic [WORD_BITS+ELEM_BITS-1:0] w;
        w = (WORD_BITS + ELEM_BITS)'(v);
        return w[WORD_BITS-1:0];
    endfunction

    // Stored word as presented on the element port, zero padded.
    function automatic logic [ELEM_BITS-1:0] word_to_elem(input word_t v);
        logic [WORD_BITS+ELEM_BITS-1:0] w;
        w = (WORD_BITS + ELEM_BITS)'(v);
        return w[ELEM_BITS-1:0];
    endfunction

    // Position as presented on the index port (low INDEX_BITS bits).
    function automatic logic [INDEX_BITS-1:0] pos_to_index(input pos_t p);
        logic [IDX_W+INDEX_BITS-1:0] w;
        w = (IDX_W + INDEX_BITS)'(p);
        return w[INDEX_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/asss_cell.sv
// ----------------------------------------------------------------------------
// asss_cell: one storage cell of the ring
// Holds one word. It loads on a write to its position, takes its right
// neighbor's word on a rotate, and does one compare-exchange step of the
// odd-even transposition sort with the neighbor its phase pairs it with.
// ----------------------------------------------------------------------------
module asss_cell (
    input  logic                 clk,
    input  asss_pkg::pos_t       pos,
    input  asss_pkg::cell_ctrl_t ctrl,
    input  asss_pkg::word_t      left,
    input  asss_pkg::word_t      right,
    output asss_pkg::word_t      word
);
    import asss_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  pair_low;
    logic  pair_high;
    cnt_t  pos_cnt;

    assign pos_cnt = CNT_W'(pos);

    // Low member of a pair compares with the right cell, high member with the left.
    assign pair_low  = (pos[0] == ctrl.phase) && ((pos_cnt + 1'b1) < ctrl.fill);
    assign pair_high = (pos != '0) && (pos[0] != ctrl.phase) && (pos_cnt < ctrl.fill);

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.wr_en && (ctrl.wr_idx == pos))
        begin
            word_next = ctrl.wr_word;
        end
        else if (ctrl.shift)
        begin
            word_next = right;
        end
        else if (ctrl.sort_en)
        begin
            if (pair_low && ($signed(word_reg) > $signed(right)))
            begin
                word_next = right;
            end
            else if (pair_high && ($signed(left) > $signed(word_reg)))
            begin
                word_next = left;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> hw/rtl/asss_ctrl.sv
// ----------------------------------------------------------------------------
// asss_ctrl: operation sequencer and result register
// Decodes each command, drives the cell chain (write, rotate, sort phases),
// watches the word at the head of the ring and holds the outgoing result.
// ----------------------------------------------------------------------------
module asss_ctrl (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [asss_pkg::FUNC_BITS-1:0]           func,
    input  logic signed [asss_pkg::ELEM_BITS-1:0]    value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [asss_pkg::STATUS_BITS-1:0]         status,
    output logic [asss_pkg::INDEX_BITS-1:0]          index,
    output logic signed [asss_pkg::ELEM_BITS-1:0]    element,
    output logic                                     last,
    input  asss_pkg::word_t                          head,
    output asss_pkg::cell_ctrl_t                     cell_ctrl
);
    import asss_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SORT  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_BIN   = 3'd4;
    localparam logic [2:0] S_RET   = 3'd5;

    localparam pos_t POS_LAST = IDX_W'(DEPTH - 1);
    localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

    logic [2:0]           state_reg, state_next;
    logic [FUNC_BITS-1:0] func_reg, func_next;
    word_t                key_reg, key_next;
    cnt_t                 fill_reg, fill_next;
    pos_t                 rot_reg, rot_next;
    pos_t                 sort_cnt_reg, sort_cnt_next;
    logic                 found_reg, found_next;
    pos_t                 found_idx_reg, found_idx_next;
    logic signed [CNT_W:0] lo_reg, lo_next;
    logic signed [CNT_W:0] hi_reg, hi_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [INDEX_BITS-1:0]   index_reg;
    logic [ELEM_BITS-1:0]    element_reg;
    logic                    last_reg;

    logic                    slot_free;
    logic                    emit;
    logic [STATUS_BITS-1:0]  e_status;
    pos_t                    e_pos;
    word_t                   e_word;
    logic                    e_last;

    pos_t                    rot_inc;
    logic                    rot_in_fill;
    logic                    head_match;
    logic signed [CNT_W+1:0] bin_sum;
    pos_t                    mid;
    logic signed [CNT_W:0]   mid_s;

    assign slot_free   = !out_valid_reg || out_ready;
    assign rot_inc     = (rot_reg == POS_LAST) ? '0 : rot_reg + 1'b1;
    assign rot_in_fill = CNT_W'(rot_reg) < fill_reg;
    assign head_match  = (head == key_reg);
    assign bin_sum     = (CNT_W + 2)'(lo_reg) + (CNT_W + 2)'(hi_reg);
    assign mid         = IDX_W'(bin_sum >>> 1);
    assign mid_s       = $signed({1'b0, CNT_W'(mid)});

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        rot_next       = rot_reg;
        sort_cnt_next  = sort_cnt_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        in_ready       = 1'b0;
        emit           = 1'b0;
        e_status       = ST_OK;
        e_pos          = '0;
        e_word         = '0;
        e_last         = 1'b1;
        cell_ctrl         = '0;
        cell_ctrl.fill    = fill_reg;
        cell_ctrl.phase   = sort_cnt_reg[0];
        cell_ctrl.wr_idx  = fill_reg[IDX_W-1:0];
        cell_ctrl.wr_word = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next  = func;
                    key_next   = value_to_word(value);
                    state_next = S_START;
                end
            end

            S_START:
            begin
                case (func_reg)
                    F_APPEND:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (fill_reg == CNT_FULL)
                            begin
                                e_status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.wr_en = 1'b1;
                                e_pos           = fill_reg[IDX_W-1:0];
                                e_word          = key_reg;
                                fill_next       = fill_reg + 1'b1;
                            end
                        end
                    end
                    F_LSEARCH:
                    begin
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    F_SORT, F_LIST:
                    begin
                        if (fill_reg == '0)
                        begin
                            if (slot_free)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else if (func_reg == F_SORT)
                        begin
                            sort_cnt_next = '0;
                            state_next    = S_SORT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    F_BSEARCH:
                    begin
                        lo_next    = '0;
                        hi_next    = $signed({1'b0, fill_reg}) - (CNT_W + 1)'(1);
                        state_next = S_BIN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SORT:
            begin
                // DEPTH odd-even phases sort any fill of the chain.
                cell_ctrl.sort_en = 1'b1;
                sort_cnt_next     = sort_cnt_reg + 1'b1;
                if (sort_cnt_reg == POS_LAST)
                begin
                    func_next  = F_LIST;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One full revolution, one entry passes the head per step.
                if (slot_free)
                begin
                    cell_ctrl.shift = 1'b1;
                    rot_next        = rot_inc;
                    if (func_reg == F_LIST)
                    begin
                        if (rot_in_fill)
                        begin
                            emit   = 1'b1;
                            e_pos  = rot_reg;
                            e_word = head;
                            e_last = (CNT_W'(rot_reg) + 1'b1) == fill_reg;
                        end
                    end
                    else
                    begin
                        if (!found_reg && rot_in_fill && head_match)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = rot_reg;
                        end
                        if (rot_reg == POS_LAST)
                        begin
                            emit = 1'b1;
                            if (found_reg)
                            begin
                                e_pos  = found_idx_reg;
                                e_word = key_reg;
                            end
                            else if (rot_in_fill && head_match)
                            begin
                                e_pos  = rot_reg;
                                e_word = key_reg;
                            end
                            else
                            begin
                                e_status = ST_NOTFOUND;
                            end
                        end
                    end
                    if (rot_reg == POS_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_BIN:
            begin
                // The ring turns every cycle; a probe resolves when mid is at the head.
                cell_ctrl.shift = 1'b1;
                rot_next        = rot_inc;
                if (lo_reg > hi_reg)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_status   = ST_NOTFOUND;
                        state_next = S_RET;
                    end
                end
                else if (rot_reg == mid)
                begin
                    if ($signed(key_reg) > $signed(head))
                    begin
                        lo_next = mid_s + (CNT_W + 1)'(1);
                    end
                    else if ($signed(key_reg) < $signed(head))
                    begin
                        hi_next = mid_s - (CNT_W + 1)'(1);
                    end
                    else if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_pos      = mid;
                        e_word     = head;
                        state_next = S_RET;
                    end
                end
            end

            S_RET:
            begin
                if (rot_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cell_ctrl.shift = 1'b1;
                    rot_next        = rot_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        sort_cnt_reg  <= sort_cnt_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        if (emit)
        begin
            status_reg  <= e_status;
            index_reg   <= pos_to_index(e_pos);
            element_reg <= word_to_elem(e_word);
            last_reg    <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;
    assign element   = element_reg;
    assign last      = last_reg;

    // The ring is only turned away from its home position while scanning, probing or returning home.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_START || state_reg == S_SORT)
        |-> (rot_reg == '0))
        else $error("ring not at home position outside a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_START) |=> $stable(fill_reg))
        else $error("fill count changed outside an append");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT) |=> !$rose(out_valid_reg))
        else $error("result produced during a sort pass");

endmodule

>>> hw/rtl/array_store_search_sort.sv
// ----------------------------------------------------------------------------
// array_store_search_sort: word store with append, searches, sort and list
// A ring of DEPTH cells holds the stored words; a sequencer appends, rotates
// the ring past a single head tap for searches and listing, and runs an
// odd-even transposition sort across neighboring cells.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------
//   input     in_valid / in_ready     func, value
//   output    out_valid / out_ready   status, index, element, last
//
// A list or linear search turns the ring once. Sort runs DEPTH
// compare-exchange phases and then lists. A binary search resolves one
// probe as its midpoint reaches the head.
// Reset clears the fill count and control state; stored words are not cleared.
// One command is in work at a time; a result waiting on the output stalls
// a list or linear search until that beat is taken, while a new command
// can be accepted as soon as the previous one has finished.
// ----------------------------------------------------------------------------
module array_store_search_sort (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [asss_pkg::FUNC_BITS-1:0]        func,
    input  logic signed [asss_pkg::ELEM_BITS-1:0] value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [asss_pkg::STATUS_BITS-1:0]      status,
    output logic [asss_pkg::INDEX_BITS-1:0]       index,
    output logic signed [asss_pkg::ELEM_BITS-1:0] element,
    output logic                                  last
);
    import asss_pkg::*;

    // Word held by each cell; cell 0 is the head the sequencer watches.
    word_t      cell_word [DEPTH];
    cell_ctrl_t cell_ctrl;

    asss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .index     (index),
        .element   (element),
        .last      (last),
        .head      (cell_word[0]),
        .cell_ctrl (cell_ctrl)
    );

    // The chain closes into a ring: the last cell rotates in from cell 0,
    // so a full revolution brings every word back to its own position.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        asss_cell u_cell (
            .clk   (clk),
            .pos   (IDX_W'(g)),
            .ctrl  (cell_ctrl),
            .left  (cell_word[(g + DEPTH - 1) % DEPTH]),
            .right (cell_word[(g + 1) % DEPTH]),
            .word  (cell_word[g])
        );
    end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the array store with search and sort
// Drives append, linear search, sort, binary search and list commands over
// the valid/ready input channel, predicts every result beat with a software
// copy of the store, and checks each output beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import asss_pkg::*;

    typedef logic signed [ELEM_BITS-1:0] elem_t;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [INDEX_BITS-1:0]  index;
        elem_t                  element;
        logic                   last;
    } result_beat_t;

    // Keeps a mirror of the store and the queue of result beats still owed.
    class store_scoreboard;
        elem_t        words [DEPTH];
        int unsigned  fill;
        result_beat_t owed_q [$];
        int           mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void owe(logic [STATUS_BITS-1:0] st, int unsigned pos, elem_t elem,
                          logic lst);
            result_beat_t b;
            b.status  = st;
            b.index   = INDEX_BITS'(pos);
            b.element = elem;
            b.last    = lst;
            owed_q.push_back(b);
        endfunction

        function void owe_listing();
            int unsigned i;
            if (fill == 0)
                owe(ST_EMPTY, 0, '0, 1'b1);
            else
                for (i = 0; i < fill; i++)
                    owe(ST_OK, i, words[i], (i + 1 == fill));
        endfunction

        // Works out the result beats caused by one accepted command.
        function void note_input(logic [FUNC_BITS-1:0] f, elem_t v);
            int unsigned i;
            int unsigned j;
            int          lo;
            int          hi;
            int          mid;
            bit          hit;
            elem_t       t;
            hit = 1'b0;
            case (f)
                F_APPEND:
                begin
                    if (fill >= DEPTH)
                        owe(ST_FULL, 0, '0, 1'b1);
                    else
                    begin
                        words[fill] = v;
                        owe(ST_OK, fill, v, 1'b1);
                        fill++;
                    end
                end
                F_LSEARCH:
                begin
                    for (i = 0; i < fill && !hit; i++)
                        if (words[i] == v)
                        begin
                            owe(ST_OK, i, words[i], 1'b1);
                            hit = 1'b1;
                        end
                    if (!hit)
                        owe(ST_NOTFOUND, 0, '0, 1'b1);
                end
                F_SORT:
                begin
                    for (i = 0; i < fill; i++)
                        for (j = i + 1; j < fill; j++)
                            if (words[i] > words[j])
                            begin
                                t        = words[i];
                                words[i] = words[j];
                                words[j] = t;
                            end
                    owe_listing();
                end
                F_BSEARCH:
                begin
                    lo = 0;
                    hi = int'(fill) - 1;
                    while (lo <= hi && !hit)
                    begin
                        mid = (lo + hi) / 2;
                        if (v > words[mid])
                            lo = mid + 1;
                        else if (v < words[mid])
                            hi = mid - 1;
                        else
                        begin
                            owe(ST_OK, mid, words[mid], 1'b1);
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        owe(ST_NOTFOUND, 0, '0, 1'b1);
                end
                F_LIST:
                    owe_listing();
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] st, logic [INDEX_BITS-1:0] idx,
                                   elem_t elem, logic lst);
            result_beat_t b;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d index %0d element %0d last %0d",
                             st, idx, elem, lst);
            end
            else
            begin
                b = owed_q.pop_front();
                if (b.status !== st || b.index !== idx || b.element !== elem
                    || b.last !== lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("beat mismatch: expected status %0d index %0d element %0d last %0d",
                                 b.status, b.index, b.element, b.last);
                        $display("               got      status %0d index %0d element %0d last %0d",
                                 st, idx, elem, lst);
                    end
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // The codes above the list operation are unused and must produce nothing.
    localparam logic [FUNC_BITS-1:0] F_UNUSED_LO = 3'd5;

    localparam int RAND_ITEMS   = 500;
    localparam int PRESSURE_AT  = 250;
    localparam int HOLD_CYCLES  = 600;
    // The drain after the last expected beat is sized to cover the longest
    // binary search with room to spare.
    localparam int DRAIN_CYCLES = DEPTH * (IDX_W + 4);
    // Slowest correct run: every command a full listing or a deep binary search,
    // each beat waiting out a long receiver stall, plus the pressure hold-off.
    // The limit below is several times that figure.
    localparam int LIMIT_CYCLES = 3_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FUNC_BITS-1:0]   func;
    elem_t                  value;
    logic                   out_valid;
    logic                   out_ready;
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  index;
    elem_t                  element;
    logic                   last;

    store_scoreboard sb;

    // Idle percentages for each side; the stimulus process changes them by phase.
    int  send_idle_pct;
    int  recv_idle_pct;
    // The pressure request comes from the stimulus; the hold-off itself is timed
    // in its own process below.
    bit   hold_req;
    logic hold_on;
    int   cycles;

    array_store_search_sort u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .index     (index),
        .element   (element),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset is held at the start and never asserted again.
    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a run that overstays the limit is a failure.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offers one command beat and waits for it to be taken. Idle cycles, if any,
    // come before the beat goes up, so valid never drops while a beat is waiting.
    // Every signal sees a single nonblocking update per clock edge.
    task automatic send_beat(logic [FUNC_BITS-1:0] f, elem_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // The beat was taken at this edge; results can only follow at later edges.
        sb.note_input(f, v);
    endtask

    // A random word: mostly full-range, with extremes and a narrow band of small
    // values so that duplicates and search hits turn up often.
    function automatic elem_t rand_word();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0:       rand_word = ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1:       rand_word = ($urandom_range(1) != 0) ? 32'sd0 : -32'sd1;
            2, 3, 4: rand_word = elem_t'(int'($urandom_range(16)) - 8);
            default: rand_word = elem_t'($urandom);
        endcase
    endfunction

    // A search key: most of the time a word that is really in the store.
    function automatic elem_t rand_key();
        if (sb.fill > 0 && $urandom_range(99) < 60)
            rand_key = sb.words[$urandom_range(sb.fill - 1, 0)];
        else
            rand_key = rand_word();
    endfunction

    // Receiver: checks each beat taken at an edge, then picks ready for the next
    // cycle. During the pressure hold-off ready stays low however long it lasts.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(status, index, element, last);
            if (hold_on)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off. The sender keeps offering beats meanwhile, so a
    // listing in flight backs up and the block has to stall its input.
    initial
    begin
        hold_on <= 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned          counted;
        int unsigned          r;
        int                   after_sort;
        logic [FUNC_BITS-1:0] f;
        elem_t                v;

        sb            = new();
        send_idle_pct = 18;
        recv_idle_pct = 87;
        hold_req      = 1'b0;
        in_valid     <= 1'b0;
        func         <= F_APPEND;
        value        <= '0;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Directed part. An empty store answers list and sort with the empty
        // status and every search with not found; unused codes produce nothing.
        send_beat(F_LIST, 32'sd0);
        send_beat(F_SORT, 32'sd0);
        send_beat(F_LSEARCH, 32'sd5);
        send_beat(F_BSEARCH, 32'sd5);
        send_beat(F_UNUSED_LO, 32'sh7FFF_FFFF);
        send_beat(F_UNUSED_LO + 3'd1, 32'sh8000_0000);
        send_beat(F_UNUSED_LO + 3'd2, -32'sd1);
        // Extreme words and alternating bit patterns.
        send_beat(F_APPEND, 32'sh7FFF_FFFF);
        send_beat(F_APPEND, 32'sh8000_0000);
        send_beat(F_APPEND, 32'sd0);
        send_beat(F_APPEND, -32'sd1);
        send_beat(F_APPEND, 32'sd1);
        send_beat(F_APPEND, 32'sh5555_5555);
        send_beat(F_APPEND, 32'shAAAA_AAAA);
        // A duplicate, so that linear search must return the first position.
        send_beat(F_APPEND, -32'sd1);
        send_beat(F_LSEARCH, -32'sd1);
        send_beat(F_LSEARCH, 32'sd2);
        send_beat(F_LIST, 32'sd0);
        // Binary search on unsorted contents is still fully predicted.
        send_beat(F_BSEARCH, 32'sd0);
        send_beat(F_SORT, 32'sd0);
        send_beat(F_BSEARCH, 32'sh7FFF_FFFF);
        send_beat(F_BSEARCH, 32'sh8000_0000);
        send_beat(F_BSEARCH, -32'sd1);
        send_beat(F_BSEARCH, 32'sd2);

        // Random part. Appends dominate early so the store fills and the full
        // case is reached; sorts are usually followed by binary searches so
        // that those land on ordered contents.
        counted    = 0;
        after_sort = 0;
        while (counted < RAND_ITEMS)
        begin
            if (counted < RAND_ITEMS / 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 87;
            end
            else if (counted < 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (counted == PRESSURE_AT)
                hold_req = 1'b1;

            r = $urandom_range(99);
            if (r < 4)
                f = F_UNUSED_LO + 3'($urandom_range(2));
            else if (after_sort > 0 && r < 74)
                f = F_BSEARCH;
            else if (r < 40)
                f = F_APPEND;
            else if (r < 58)
                f = F_LSEARCH;
            else if (r < 74)
                f = F_BSEARCH;
            else if (r < 86)
                f = F_LIST;
            else
                f = F_SORT;

            if (f == F_APPEND)
                v = rand_word();
            else if (f == F_LSEARCH || f == F_BSEARCH)
                v = rand_key();
            else
                v = elem_t'($urandom);

            if (after_sort > 0)
                after_sort--;
            if (f == F_SORT)
                after_sort = 3;

            send_beat(f, v);
            if (f <= F_LIST)
                counted++;
        end
        in_valid <= 1'b0;

        // Wait for every owed beat, then give the block time to show any extra.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
